// File: hw/rtl/csmv_pkg.sv
// Package with shared types and constants for the CSR sparse matrix-vector multiplier.
package csmv_pkg;

    localparam int IDX_W        = 10;
    localparam int VAL_W        = 32;
    localparam int ACC_W        = 48;
    localparam int PROD_W       = 2 * VAL_W;
    localparam int FRAC_W       = 16;
    localparam int VEC_SIZE_DEF = 1024;
    localparam int CMD_DEPTH    = 2;
    localparam int OUT_DEPTH    = 8;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_MAC   = 2'd1;
    localparam logic [1:0] MODE_CLOSE = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_MAC,
        OP_CLOSE
    } op_t;

    typedef struct packed {
        logic [1:0]              mode;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
        logic                    row_end;
    } in_word_t;

    typedef struct packed {
        logic [IDX_W-1:0]        row_index;
        logic signed [VAL_W-1:0] row_value;
        logic                    saturated;
    } out_word_t;

    typedef struct packed {
        op_t                     op;
        logic                    close;
        logic                    in_range;
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t data;
    } cmd_push_t;

endpackage

// File: hw/rtl/csmv_ram.sv
// Generic single-port RAM with registered read data.
module csmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hw/rtl/csmv_fifo.sv
// Small register-based first-in first-out queue with an occupancy count.
module csmv_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty,
    output logic [CW-1:0]    count
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

// File: hw/rtl/csmv_front.sv
// Front end: accepts input words, decodes the mode and range-checks the index.
module csmv_front import csmv_pkg::*; #(
    parameter int VEC_SIZE = VEC_SIZE_DEF
) (
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    input  logic      q_full,
    output cmd_push_t q_push
);

    logic accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    always_comb begin
        q_push.valid         = 1'b0;
        q_push.data.op       = OP_CLOSE;
        q_push.data.close    = 1'b1;
        q_push.data.in_range = (32'(s_data.index) < 32'(VEC_SIZE));
        q_push.data.index    = s_data.index;
        q_push.data.value    = s_data.value;
        case (s_data.mode)
            MODE_LOAD: begin
                q_push.valid      = accept;
                q_push.data.op    = OP_LOAD;
                q_push.data.close = 1'b0;
            end
            MODE_MAC: begin
                q_push.valid      = accept;
                q_push.data.op    = OP_MAC;
                q_push.data.close = s_data.row_end;
            end
            MODE_CLOSE: begin
                q_push.valid = accept;
            end
            default: begin
                // The unused mode is consumed without effect.
                q_push.valid = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/csmv_back.sv
// Back end: vector store access, multiply, row accumulation, clipping and result queue.
module csmv_back import csmv_pkg::*; #(
    parameter int VEC_SIZE = VEC_SIZE_DEF,
    localparam int CCW     = $clog2(OUT_DEPTH + 1)
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cmd_valid,
    input  cmd_t      cmd_data,
    output logic      cmd_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int AW = $clog2(VEC_SIZE);
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W - 1){1'b0}}};
    localparam logic signed [VAL_W-1:0] OUT_MAX = {1'b0, {(VAL_W - 1){1'b1}}};
    localparam logic signed [VAL_W-1:0] OUT_MIN = {1'b1, {(VAL_W - 1){1'b0}}};

    logic [XW-1:0]           idx_ext;
    logic [AW-1:0]           ram_addr;
    logic                    ram_we;
    logic [VAL_W-1:0]        ram_rdata;

    logic                    s2_valid_reg;
    op_t                     s2_op_reg;
    logic                    s2_close_reg;
    logic                    s2_in_range_reg;
    logic signed [VAL_W-1:0] s2_value_reg;
    logic signed [VAL_W-1:0] x_sel;

    logic                    s3_valid_reg;
    op_t                     s3_op_reg;
    logic                    s3_close_reg;
    logic signed [PROD_W-1:0] s3_prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    logic signed [ACC_W-1:0] row_sum_reg, row_sum_next;
    logic [IDX_W-1:0]        row_cnt_reg, row_cnt_next;
    logic signed [ACC_W-1:0] prod_q;
    logic signed [ACC_W:0]   sum_wide;
    logic signed [ACC_W-1:0] sum_sat;
    logic                    emit;
    logic signed [ACC_W-1:0] emit_sum;

    logic                    s4_valid_reg;
    logic [IDX_W-1:0]        s4_idx_reg;
    logic signed [ACC_W-1:0] s4_sum_reg;
    out_word_t               s4_word;

    logic [CCW-1:0]          out_count;
    logic                    out_full;
    logic                    out_empty;
    logic [1:0]              inflight;
    logic [CCW:0]            credit_used;
    logic [$bits(out_word_t)-1:0] out_rdata;

    assign inflight    = 2'(s2_valid_reg) + 2'(s3_valid_reg) + 2'(s4_valid_reg);
    assign credit_used = (CCW + 1)'(out_count) + (CCW + 1)'(inflight);
    assign cmd_pop     = cmd_valid && (credit_used < (CCW + 1)'(OUT_DEPTH));

    assign idx_ext  = XW'(cmd_data.index);
    assign ram_addr = idx_ext[AW-1:0];
    assign ram_we   = cmd_pop && (cmd_data.op == OP_LOAD) && cmd_data.in_range;

    csmv_ram #(
        .WIDTH(VAL_W),
        .DEPTH(VEC_SIZE)
    ) u_vec_ram (
        .aclk (aclk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(cmd_data.value),
        .rdata(ram_rdata)
    );

    assign x_sel     = s2_in_range_reg ? $signed(ram_rdata) : '0;
    assign prod_next = s2_value_reg * x_sel;

    assign prod_q   = s3_prod_reg[PROD_W-1:FRAC_W];
    assign sum_wide = {row_sum_reg[ACC_W-1], row_sum_reg} + {prod_q[ACC_W-1], prod_q};

    always_comb begin
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
            sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    always_comb begin
        row_sum_next = row_sum_reg;
        row_cnt_next = row_cnt_reg;
        emit         = 1'b0;
        emit_sum     = row_sum_reg;
        if (s3_valid_reg) begin
            case (s3_op_reg)
                OP_LOAD: begin
                    row_sum_next = '0;
                    row_cnt_next = '0;
                end
                OP_MAC: begin
                    row_sum_next = sum_sat;
                    emit_sum     = sum_sat;
                    emit         = s3_close_reg;
                end
                OP_CLOSE: begin
                    emit = 1'b1;
                end
                default: begin
                    row_sum_next = row_sum_reg;
                end
            endcase
            if (emit) begin
                row_sum_next = '0;
                row_cnt_next = row_cnt_reg + 1'b1;
            end
        end
    end

    always_comb begin
        s4_word.row_index = s4_idx_reg;
        s4_word.saturated = 1'b0;
        s4_word.row_value = s4_sum_reg[VAL_W-1:0];
        if (s4_sum_reg[ACC_W-1:VAL_W-1] != {(ACC_W - VAL_W + 1){s4_sum_reg[ACC_W-1]}}) begin
            s4_word.saturated = 1'b1;
            s4_word.row_value = s4_sum_reg[ACC_W-1] ? OUT_MIN : OUT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            row_sum_reg  <= '0;
            row_cnt_reg  <= '0;
        end else begin
            s2_valid_reg <= cmd_pop;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= emit;
            row_sum_reg  <= row_sum_next;
            row_cnt_reg  <= row_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        s2_op_reg       <= cmd_data.op;
        s2_close_reg    <= cmd_data.close;
        s2_in_range_reg <= cmd_data.in_range;
        s2_value_reg    <= cmd_data.value;
        s3_op_reg       <= s2_op_reg;
        s3_close_reg    <= s2_close_reg;
        s3_prod_reg     <= prod_next;
        s4_idx_reg      <= row_cnt_reg;
        s4_sum_reg      <= emit_sum;
    end

    csmv_fifo #(
        .WIDTH($bits(out_word_t)),
        .DEPTH(OUT_DEPTH)
    ) u_out_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (s4_valid_reg),
        .wdata  (s4_word),
        .pop    (m_valid && m_ready),
        .rdata  (out_rdata),
        .full   (out_full),
        .empty  (out_empty),
        .count  (out_count)
    );

    assign m_valid = !out_empty;
    assign m_data  = out_word_t'(out_rdata);

    a_out_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_valid_reg |-> !out_full)
        else $error("result queue written while full");

    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_used <= (CCW + 1)'(OUT_DEPTH))
        else $error("in-flight words exceed result queue room");

    a_load_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s3_valid_reg && s3_op_reg == OP_LOAD) |=> (row_cnt_reg == '0 && row_sum_reg == '0))
        else $error("vector load did not restart the row");

    a_emit_index: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> (s4_valid_reg && s4_idx_reg == $past(row_cnt_reg)
                  && row_cnt_reg == $past(row_cnt_reg) + 1'b1))
        else $error("closed row index or row counter out of step");

endmodule

// File: hw/rtl/csr_sparse_matrix_vector_multiply.sv
// Top level of the CSR sparse matrix-vector multiplier.
//
//   channel  direction  handshake           word
//   s_       in         s_valid / s_ready   in_word_t  (mode, index, value, row_end)
//   m_       out        m_valid / m_ready   out_word_t (row_index, row_value, saturated)
//
// One word is accepted per cycle while the command queue has room (s_ready high); a closed
// row passes the command queue, the registered vector store read, the multiplier register
// and the row result register ahead of the result queue, and is then offered on m_.
// Reset clears control state and the row sum and counter; the vector store is not cleared.
// Words are issued from the command queue only while the result queue has room for every
// word in flight, so a stalled m_ready fills the result queue and then drops s_ready.
module csr_sparse_matrix_vector_multiply import csmv_pkg::*; #(
    parameter int VEC_SIZE = VEC_SIZE_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int QCW = $clog2(CMD_DEPTH + 1);

    cmd_push_t               q_push;
    logic                    q_full;
    logic                    q_empty;
    logic                    q_pop;
    logic [QCW-1:0]          q_count;
    logic [$bits(cmd_t)-1:0] q_rdata;

    csmv_front #(
        .VEC_SIZE(VEC_SIZE)
    ) u_front (
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .q_full (q_full),
        .q_push (q_push)
    );

    csmv_fifo #(
        .WIDTH($bits(cmd_t)),
        .DEPTH(CMD_DEPTH)
    ) u_cmd_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push.valid),
        .wdata  (q_push.data),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .full   (q_full),
        .empty  (q_empty),
        .count  (q_count)
    );

    csmv_back #(
        .VEC_SIZE(VEC_SIZE)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_valid(!q_empty),
        .cmd_data (cmd_t'(q_rdata)),
        .cmd_pop  (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_cmd_count: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCW'(CMD_DEPTH))
        else $error("command queue count beyond depth");

endmodule
